FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define BCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define BCM_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/bcm_pkg.sv
`default_nettype none

package bcm_pkg;

  // Job dimensions
  localparam int SENDERS     = 8;
  localparam int RECEIVERS   = 8;
  localparam int RECV_USED   = (RECEIVERS < 8) ? RECEIVERS : 8;
  localparam int STACK_DEPTH = SENDERS + 1;

  // Derived widths
  localparam int SND_W = (SENDERS > 1) ? $clog2(SENDERS) : 1;     // sender number
  localparam int RV_W  = (RECV_USED > 1) ? $clog2(RECV_USED) : 1; // receiver number
  localparam int RS_W  = $clog2(RECV_USED + 1);                   // scan start, to RECV_USED
  localparam int RL_W  = $clog2(SENDERS + 1);                     // row and match counts
  localparam int DP_W  = $clog2(STACK_DEPTH + 1);                 // stack depth
  localparam int SI_W  = $clog2(STACK_DEPTH);                     // stack index

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // One result item
  typedef struct packed {
    logic       last_result;
    logic [3:0] match_count;
    logic [2:0] assigned_sender;
    logic       assigned;
    logic [2:0] receiver_index;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bcm_scan.sv
`default_nettype none

// Shared scan unit: lowest requested, unvisited receiver at or above start.
module bcm_scan import bcm_pkg::*; (
  input  wire logic [RECV_USED-1:0] row,
  input  wire logic [RECV_USED-1:0] visited,
  input  wire logic [RS_W-1:0]      start,
  output logic                      found,
  output logic [RV_W-1:0]           idx
);

  logic [RECV_USED-1:0] cand;

  // candidate bits
  always_comb begin
    for (int v = 0; v < RECV_USED; v++) begin
      cand[v] = row[v] & ~visited[v] & (RS_W'(v) >= start);
    end
  end

  // priority encode, lowest index wins
  always_comb begin
    idx = '0;
    for (int v = RECV_USED - 1; v >= 0; v--) begin
      if (cand[v]) begin
        idx = RV_W'(v);
      end
    end
  end

  assign found = |cand;

endmodule

`default_nettype wire

FILE: hw/rtl/bcm_ctrl.sv
`default_nettype none

// Sequencer, row store, ownership table and search stack.
module bcm_ctrl import bcm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [IN_DATA_W-1:0] request_mask,
  input  wire logic                 last_row,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output result_t                   res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POP,
    S_AUG,
    S_FINISH,
    S_EMIT
  } state_t;

  state_t state;

  // control state
  logic [DP_W-1:0]      depth;
  logic [RS_W-1:0]      start;
  logic [RECV_USED-1:0] visited;
  logic [RECV_USED-1:0] owner_vld;
  logic [RL_W-1:0]      rows_loaded;
  logic [RL_W-1:0]      matched;
  logic                 last_pend;
  logic [RV_W-1:0]      emit_idx;

  // storage
  logic [RECV_USED-1:0] rows    [SENDERS];
  logic [SND_W-1:0]     owner   [RECV_USED];
  logic [SND_W-1:0]     stk_snd [STACK_DEPTH];
  logic [RV_W-1:0]      stk_rcv [STACK_DEPTH];

  logic [SI_W-1:0]      top_idx;
  logic [SND_W-1:0]     top_snd;
  logic [RV_W-1:0]      top_rcv;
  logic                 scan_found;
  logic [RV_W-1:0]      scan_v;
  logic [RV_W-1:0]      own_addr;
  logic [SND_W-1:0]     own_q;
  logic                 own_vld_q;
  logic                 accept;
  logic                 row_taken;
  logic                 emit_last;

  assign top_idx   = SI_W'(depth - DP_W'(1));
  assign top_snd   = stk_snd[top_idx];
  assign top_rcv   = stk_rcv[top_idx];

  bcm_scan u_scan (
    .row     (rows[top_snd]),
    .visited (visited),
    .start   (start),
    .found   (scan_found),
    .idx     (scan_v)
  );

  // one owner read port, shared by search and result phases
  assign own_addr  = (state == S_EMIT) ? emit_idx : scan_v;
  assign own_q     = owner[own_addr];
  assign own_vld_q = owner_vld[own_addr];

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign row_taken = (rows_loaded < RL_W'(SENDERS));
  assign emit_last = (emit_idx == RV_W'(RECV_USED - 1));

  // result item
  assign res_valid           = (state == S_EMIT);
  assign res.receiver_index  = 3'(emit_idx);
  assign res.assigned        = own_vld_q;
  assign res.assigned_sender = own_vld_q ? 3'(own_q) : 3'd0;
  assign res.match_count     = 4'(matched);
  assign res.last_result     = emit_last;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      depth       <= '0;
      start       <= '0;
      visited     <= '0;
      owner_vld   <= '0;
      rows_loaded <= '0;
      matched     <= '0;
      last_pend   <= 1'b0;
      emit_idx    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            last_pend <= last_row;
            if (row_taken) begin
              depth       <= DP_W'(1);
              start       <= '0;
              visited     <= '0;
              rows_loaded <= rows_loaded + RL_W'(1);
              state       <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (!scan_found) begin
            // branch exhausted
            depth <= depth - DP_W'(1);
            state <= (depth == DP_W'(1)) ? S_FINISH : S_POP;
          end else begin
            visited[scan_v] <= 1'b1;
            if (!own_vld_q) begin
              state <= S_AUG;
            end else if (depth < DP_W'(STACK_DEPTH)) begin
              depth <= depth + DP_W'(1);
              start <= '0;
            end else begin
              start <= RS_W'(scan_v) + RS_W'(1);
            end
          end
        end
        S_POP: begin
          start <= RS_W'(top_rcv) + RS_W'(1);
          state <= S_SCAN;
        end
        S_AUG: begin
          // flip one frame per cycle, top first
          owner_vld[top_rcv] <= 1'b1;
          depth <= depth - DP_W'(1);
          if (depth == DP_W'(1)) begin
            matched <= matched + RL_W'(1);
            state   <= S_FINISH;
          end
        end
        S_FINISH: begin
          emit_idx <= '0;
          state    <= last_pend ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (res_ready) begin
            emit_idx <= emit_idx + RV_W'(1);
            if (emit_last) begin
              owner_vld   <= '0;
              rows_loaded <= '0;
              matched     <= '0;
              state       <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload storage writes
  always_ff @(posedge clk) begin
    if (accept && row_taken) begin
      rows[rows_loaded[SND_W-1:0]] <= request_mask[RECV_USED-1:0];
      stk_snd[0] <= rows_loaded[SND_W-1:0];
      stk_rcv[0] <= '0;
    end
    if (state == S_SCAN && scan_found) begin
      stk_rcv[top_idx] <= scan_v;
      if (own_vld_q && depth < DP_W'(STACK_DEPTH)) begin
        stk_snd[SI_W'(depth)] <= own_q;
        stk_rcv[SI_W'(depth)] <= '0;
      end
    end
    if (state == S_AUG) begin
      owner[top_rcv] <= top_snd;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bipartite_channel_matcher.sv
`default_nettype none
`include "assert_macros.svh"

// Maximum bipartite matcher. Each input item is one transmitter row (a mask of the
// receivers it has packets for); transmitters are numbered in arrival order and rows
// beyond SENDERS are dropped. Each stored row starts a depth-first augmenting-path
// search run by a small sequencer around one receiver-scan unit, which takes one step
// per cycle: every scan either visits a receiver or backs off through an extra pop
// step, and a successful path is rewritten one frame per cycle. The input is not
// ready while a row is being processed. After the row with tlast set, one result per
// receiver leaves through the output register at one per cycle while the output is
// not stalled, lowest receiver first, then the job state is cleared.
module bipartite_channel_matcher import bcm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] request_mask
  input  wire logic                  s_axis_tlast,  // last_row
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // receiver_index, assigned,
                                                    // assigned_sender, match_count, zeros
  output logic                       m_axis_tlast   // last_result
);

  result_t res;
  logic    res_valid;
  logic    res_ready;

  bcm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .request_mask (s_axis_tdata),
    .last_row     (s_axis_tlast),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {5'd0, res.match_count, res.assigned_sender,
                       res.assigned, res.receiver_index};
      m_axis_tlast <= res.last_result;
    end
  end

  // checks
  `BCM_ASSERT(a_busy_after_item, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready,
              "input still ready after an item was taken")
  `BCM_ASSERT(a_idle_after_last, (res_valid && res_ready && res.last_result) |=> s_axis_tready,
              "not idle after the last result")
  `BCM_ASSERT_NEVER(a_ready_while_emit, s_axis_tready && res_valid,
                    "input ready while results are pending")

endmodule

`default_nettype wire
